// ===== rtl/tcw_pkg.sv =====
// shared types, constants and microcode for the text console writer
package tcw_pkg;

  localparam int COLUMNS_DEF = 100;
  localparam int ROWS_DEF    = 37;

  localparam int COL_W  = 7;
  localparam int ROW_W  = 6;
  localparam int CELL_W = 16;

  localparam logic [7:0]        ATTR_RESET     = 8'h0F;
  localparam logic [7:0]        CHAR_SPACE     = 8'h20;
  localparam logic [7:0]        CHAR_NEWLINE   = 8'h0A;
  localparam logic [7:0]        CHAR_BACKSPACE = 8'h08;
  localparam logic [7:0]        CHAR_NULL      = 8'h00;
  localparam logic [CELL_W-1:0] CELL_ZERO      = 16'h0000;
  localparam logic [CELL_W-1:0] CELL_BLANK     = {ATTR_RESET, CHAR_SPACE};

  typedef enum logic [1:0] {
    CMD_PUT   = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [1:0]       command;
    logic [7:0]       char_code;
    logic [ROW_W-1:0] cell_row;
    logic [COL_W-1:0] cell_col;
  } tcw_req_t;

  typedef struct packed {
    logic [COL_W-1:0]  cursor_col;
    logic [ROW_W-1:0]  cursor_row;
    logic [CELL_W-1:0] cell_value;
    logic              scrolled;
  } tcw_rsp_t;

  // microcode steps
  typedef enum logic [3:0] {
    S_IDLE,
    S_PUT,
    S_NEWLINE,
    S_CHKSCR,
    S_SCR_INIT,
    S_COPY,
    S_ZERO_SET,
    S_ZERO,
    S_BKSP,
    S_BKWR,
    S_READ,
    S_READWB,
    S_CLEAR,
    S_FILL,
    S_EMIT
  } step_t;

  // datapath operations
  typedef enum logic [3:0] {
    OP_LATCH,
    OP_PUT,
    OP_NEWLINE,
    OP_NONE,
    OP_SCR_INIT,
    OP_COPY,
    OP_ZERO_SET,
    OP_ZERO,
    OP_BKSP,
    OP_BKWR,
    OP_READ,
    OP_READWB,
    OP_CLR_INIT,
    OP_FILL,
    OP_EMIT
  } op_t;

  // jump conditions
  typedef enum logic [2:0] {
    C_ALWAYS,
    C_DISPATCH,
    C_ROW_OVER,
    C_HOME,
    C_COPY_DONE,
    C_SWEEP_DONE,
    C_OUT_FREE
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t jt;
    step_t jf;
  } uword_t;

  typedef struct packed {
    logic row_over;
    logic at_home;
    logic copy_done;
    logic sweep_done;
    logic out_free;
  } tcw_status_t;

  // control store: one word per step
  function automatic uword_t urom(input step_t s);
    uword_t w;
    case (s)
      S_IDLE:     w = '{op: OP_LATCH,    cond: C_DISPATCH,   jt: S_IDLE,     jf: S_IDLE};
      S_PUT:      w = '{op: OP_PUT,      cond: C_ALWAYS,     jt: S_CHKSCR,   jf: S_CHKSCR};
      S_NEWLINE:  w = '{op: OP_NEWLINE,  cond: C_ALWAYS,     jt: S_CHKSCR,   jf: S_CHKSCR};
      S_CHKSCR:   w = '{op: OP_NONE,     cond: C_ROW_OVER,   jt: S_SCR_INIT, jf: S_EMIT};
      S_SCR_INIT: w = '{op: OP_SCR_INIT, cond: C_ALWAYS,     jt: S_COPY,     jf: S_COPY};
      S_COPY:     w = '{op: OP_COPY,     cond: C_COPY_DONE,  jt: S_ZERO_SET, jf: S_COPY};
      S_ZERO_SET: w = '{op: OP_ZERO_SET, cond: C_ALWAYS,     jt: S_ZERO,     jf: S_ZERO};
      S_ZERO:     w = '{op: OP_ZERO,     cond: C_SWEEP_DONE, jt: S_EMIT,     jf: S_ZERO};
      S_BKSP:     w = '{op: OP_BKSP,     cond: C_HOME,       jt: S_EMIT,     jf: S_BKWR};
      S_BKWR:     w = '{op: OP_BKWR,     cond: C_ALWAYS,     jt: S_EMIT,     jf: S_EMIT};
      S_READ:     w = '{op: OP_READ,     cond: C_ALWAYS,     jt: S_READWB,   jf: S_READWB};
      S_READWB:   w = '{op: OP_READWB,   cond: C_ALWAYS,     jt: S_EMIT,     jf: S_EMIT};
      S_CLEAR:    w = '{op: OP_CLR_INIT, cond: C_ALWAYS,     jt: S_FILL,     jf: S_FILL};
      S_FILL:     w = '{op: OP_FILL,     cond: C_SWEEP_DONE, jt: S_EMIT,     jf: S_FILL};
      S_EMIT:     w = '{op: OP_EMIT,     cond: C_OUT_FREE,   jt: S_IDLE,     jf: S_EMIT};
      default:    w = '{op: OP_NONE,     cond: C_ALWAYS,     jt: S_IDLE,     jf: S_IDLE};
    endcase
    return w;
  endfunction

  // entry step for a newly accepted transaction
  function automatic step_t dispatch(input logic [1:0] command, input logic [7:0] char_code);
    step_t s;
    case (command)
      CMD_PUT: begin
        if (char_code == CHAR_NEWLINE) begin
          s = S_NEWLINE;
        end else if (char_code == CHAR_BACKSPACE) begin
          s = S_BKSP;
        end else if (char_code == CHAR_NULL) begin
          s = S_EMIT;
        end else begin
          s = S_PUT;
        end
      end
      CMD_READ:  s = S_READ;
      CMD_CLEAR: s = S_CLEAR;
      default:   s = S_EMIT;
    endcase
    return s;
  endfunction

endpackage

// ===== rtl/tcw_ram.sv =====
// generic single write port, single read port ram with registered read
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/tcw_seq.sv =====
// microcode sequencer: step counter, control store and jump logic
module tcw_seq (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_accept,
  input  tcw_pkg::tcw_req_t   req,
  input  tcw_pkg::tcw_status_t status,
  output tcw_pkg::op_t        op,
  output logic                idle
);

  tcw_pkg::step_t  step;
  tcw_pkg::step_t  step_next;
  tcw_pkg::uword_t word;
  logic            cond_true;

  assign word = tcw_pkg::urom(step);
  assign op   = word.op;
  assign idle = (step == tcw_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= tcw_pkg::S_IDLE;
    end else begin
      step <= step_next;
    end
  end

  always_comb begin
    case (word.cond)
      tcw_pkg::C_ALWAYS:     cond_true = 1'b1;
      tcw_pkg::C_DISPATCH:   cond_true = req_accept;
      tcw_pkg::C_ROW_OVER:   cond_true = status.row_over;
      tcw_pkg::C_HOME:       cond_true = status.at_home;
      tcw_pkg::C_COPY_DONE:  cond_true = status.copy_done;
      tcw_pkg::C_SWEEP_DONE: cond_true = status.sweep_done;
      tcw_pkg::C_OUT_FREE:   cond_true = status.out_free;
      default:               cond_true = 1'b0;
    endcase

    if (word.cond == tcw_pkg::C_DISPATCH && cond_true) begin
      step_next = tcw_pkg::dispatch(req.command, req.char_code);
    end else if (cond_true) begin
      step_next = word.jt;
    end else begin
      step_next = word.jf;
    end
  end

endmodule

// ===== rtl/tcw_dp.sv =====
// datapath: cursor, sweep counter, attribute, cell buffer and result register
module tcw_dp #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  tcw_pkg::op_t         op,
  input  logic                 req_accept,
  input  tcw_pkg::tcw_req_t    req,
  input  logic                 cfg_write,
  input  logic [7:0]           cfg_data,
  input  logic                 rsp_stall,
  output logic                 rsp_valid,
  output tcw_pkg::tcw_rsp_t    rsp,
  output tcw_pkg::tcw_status_t status
);

  localparam int CELLS      = ROWS * COLUMNS;
  localparam int AW         = $clog2(CELLS);
  localparam int CW         = $clog2(COLUMNS);
  localparam int RW         = $clog2(ROWS + 1);
  localparam int SCROLL_END = CELLS - COLUMNS;
  localparam int COL_W      = tcw_pkg::COL_W;
  localparam int ROW_W      = tcw_pkg::ROW_W;

  logic [CW-1:0]              col;
  logic [RW-1:0]              row;
  logic [7:0]                 attr;
  logic [AW-1:0]              cnt;
  logic [7:0]                 char_code;
  logic [ROW_W-1:0]           rd_row;
  logic [COL_W-1:0]           rd_col;
  logic                       in_range;
  logic [tcw_pkg::CELL_W-1:0] cell_value;
  logic                       scrolled;

  logic [AW-1:0]              cur_addr;
  logic [AW-1:0]              read_addr;
  logic                       range_ok;
  logic                       out_free;
  logic [CW+COL_W-1:0]        col_ext;
  logic [RW+ROW_W-1:0]        row_ext;

  logic                       wr_en;
  logic [AW-1:0]              wr_addr;
  logic [tcw_pkg::CELL_W-1:0] wr_data;
  logic                       rd_en;
  logic [AW-1:0]              rd_addr;
  logic [tcw_pkg::CELL_W-1:0] rd_data;

  assign cur_addr  = AW'(int'(row) * COLUMNS + int'(col));
  assign read_addr = AW'(int'(rd_row) * COLUMNS + int'(rd_col));
  assign range_ok  = (int'(rd_row) < ROWS) && (int'(rd_col) < COLUMNS);
  assign out_free  = !rsp_valid || !rsp_stall;
  assign col_ext   = {{COL_W{1'b0}}, col};
  assign row_ext   = {{ROW_W{1'b0}}, row};

  assign status.row_over   = (int'(row) == ROWS);
  assign status.at_home    = (row == '0) && (col == '0);
  assign status.copy_done  = (cnt == AW'(SCROLL_END));
  assign status.sweep_done = (cnt == AW'(CELLS - 1));
  assign status.out_free   = out_free;

  // memory port selection
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cnt;
    wr_data = tcw_pkg::CELL_ZERO;
    rd_en   = 1'b0;
    rd_addr = AW'(int'(cnt) + COLUMNS);
    case (op)
      tcw_pkg::OP_PUT: begin
        wr_en   = 1'b1;
        wr_addr = cur_addr;
        wr_data = {attr, char_code};
      end
      tcw_pkg::OP_BKWR: begin
        wr_en   = 1'b1;
        wr_addr = cur_addr;
      end
      tcw_pkg::OP_COPY: begin
        // write back the cell read by the previous copy step, read the next one
        wr_en   = (cnt != '0);
        wr_addr = cnt - AW'(1);
        wr_data = rd_data;
        rd_en   = (cnt != AW'(SCROLL_END));
      end
      tcw_pkg::OP_ZERO: begin
        wr_en = 1'b1;
      end
      tcw_pkg::OP_FILL: begin
        wr_en   = 1'b1;
        wr_data = tcw_pkg::CELL_BLANK;
      end
      tcw_pkg::OP_READ: begin
        rd_en   = range_ok;
        rd_addr = read_addr;
      end
      default: begin
      end
    endcase
  end

  tcw_ram #(
    .WIDTH (tcw_pkg::CELL_W),
    .DEPTH (CELLS)
  ) u_cells (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      col       <= '0;
      row       <= '0;
      attr      <= tcw_pkg::ATTR_RESET;
      rsp_valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        attr <= cfg_data;
      end
      // a new response fills the slot, else an accepted one leaves it
      if (op == tcw_pkg::OP_EMIT && out_free) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (op)
        tcw_pkg::OP_PUT: begin
          if (col == CW'(COLUMNS - 1)) begin
            col <= '0;
            row <= row + 1'b1;
          end else begin
            col <= col + 1'b1;
          end
        end
        tcw_pkg::OP_NEWLINE: begin
          col <= '0;
          row <= row + 1'b1;
        end
        tcw_pkg::OP_BKSP: begin
          if (col != '0) begin
            col <= col - 1'b1;
          end else if (row != '0) begin
            row <= row - 1'b1;
            col <= CW'(COLUMNS - 1);
          end
        end
        tcw_pkg::OP_SCR_INIT: begin
          row <= RW'(ROWS - 1);
        end
        tcw_pkg::OP_CLR_INIT: begin
          col  <= '0;
          row  <= '0;
          attr <= tcw_pkg::ATTR_RESET;
        end
        default: begin
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (op)
      tcw_pkg::OP_LATCH: begin
        if (req_accept) begin
          char_code  <= req.char_code;
          rd_row     <= req.cell_row;
          rd_col     <= req.cell_col;
          cell_value <= tcw_pkg::CELL_ZERO;
          scrolled   <= 1'b0;
        end
      end
      tcw_pkg::OP_SCR_INIT: begin
        cnt      <= '0;
        scrolled <= 1'b1;
      end
      tcw_pkg::OP_COPY, tcw_pkg::OP_ZERO, tcw_pkg::OP_FILL: begin
        cnt <= cnt + 1'b1;
      end
      tcw_pkg::OP_ZERO_SET: begin
        cnt <= AW'(SCROLL_END);
      end
      tcw_pkg::OP_CLR_INIT: begin
        cnt <= '0;
      end
      tcw_pkg::OP_READ: begin
        in_range <= range_ok;
      end
      tcw_pkg::OP_READWB: begin
        cell_value <= in_range ? rd_data : tcw_pkg::CELL_ZERO;
      end
      tcw_pkg::OP_EMIT: begin
        if (out_free) begin
          rsp.cursor_col <= col_ext[COL_W-1:0];
          rsp.cursor_row <= row_ext[ROW_W-1:0];
          rsp.cell_value <= cell_value;
          rsp.scrolled   <= scrolled;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== rtl/text_console_writer.sv =====
// top level of the text console writer
//
// request channel (req_valid, req_stall, req): one transaction carries a command
//   put character, read cell or clear screen, with its character and read position
// response channel (rsp_valid, rsp_stall, rsp): exactly one transaction per request,
//   giving the cursor after the command, the read cell (zero for other commands)
//   and whether the screen scrolled
// config channel (cfg_valid, cfg_ready, cfg_data): writes the attribute byte that
//   goes in the high byte of each cell that a put writes; taken only while the block is idle
// each request runs a microcode program on the single ram write port, from
//   acceptance back to the idle step: a null byte or unused command goes straight
//   to emit; put, newline, backspace and read run their own steps first; a put
//   or newline that scrolls then moves rows up one cell per cycle and zeroes the
//   last row; clear writes every cell before emit
// the response sits in an output register, so a new request is accepted while the
//   previous response is still stalled; its own response then waits for that slot
// reset clears the cursor to home and the attribute to 15; the cell buffer holds
//   whatever it held and has no clearing pass, so cells are defined once written
module text_console_writer #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  tcw_pkg::tcw_req_t req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output tcw_pkg::tcw_rsp_t rsp,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [7:0]        cfg_data
);

  logic                 idle;
  logic                 req_accept;
  logic                 cfg_write;
  tcw_pkg::op_t         op;
  tcw_pkg::tcw_status_t status;

  // requests and config writes are only taken while the sequencer waits in its idle step
  assign req_stall  = !idle;
  assign cfg_ready  = idle;
  assign req_accept = req_valid && !req_stall;
  assign cfg_write  = cfg_valid && cfg_ready;

  // control store and step counter
  tcw_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .req_accept (req_accept),
    .req        (req),
    .status     (status),
    .op         (op),
    .idle       (idle)
  );

  // cursor, sweep counter, cell buffer and output register
  tcw_dp #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .op         (op),
    .req_accept (req_accept),
    .req        (req),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data),
    .rsp_stall  (rsp_stall),
    .rsp_valid  (rsp_valid),
    .rsp        (rsp),
    .status     (status)
  );

  // an accepted request always leaves the idle step
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_accept |=> req_stall)
    else $error("sequencer stayed idle after a request transaction");

  // the reported cursor row is always on screen, after any scroll
  a_row_on_screen: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (int'(rsp.cursor_row) < ROWS))
    else $error("reported cursor row beyond last row");

  // a scroll always leaves the cursor on the last row
  a_scroll_last_row: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.scrolled) |-> (int'(rsp.cursor_row) == ROWS - 1))
    else $error("scroll reported with cursor off the last row");

endmodule

// ===== dv/tb.sv =====
// self-checking testbench for the text console writer
`timescale 1ns / 100ps

module tb;
  import tcw_pkg::*;

  localparam int COLUMNS = COLUMNS_DEF;
  localparam int ROWS    = ROWS_DEF;
  localparam int CELLS   = ROWS * COLUMNS;
  // worst case is a scroll or clear on every item, each sweeping all 3700 cells,
  // plus random stalls on both sides; several times that is still far below this
  localparam int unsigned CYCLE_LIMIT = 30_000_000;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       req_valid = 1'b0;
  logic       req_stall;
  tcw_req_t   req = '0;
  logic       rsp_valid;
  logic       rsp_stall = 1'b0;
  tcw_rsp_t   rsp;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_data = '0;

  // idle percentages for the request sender and the response receiver
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // shadow copy of the console: attribute, cursor and every cell
  logic [7:0]        text_attr = ATTR_RESET;
  int                cur_col = 0;
  int                cur_row = 0;
  logic [CELL_W-1:0] screen [CELLS];

  // predicted status, one per accepted request, oldest first
  tcw_rsp_t status_due [$];

  int          mismatch_count = 0;
  int unsigned cycle_count = 0;

  text_console_writer dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // watchdog: a hung handshake ends the run here
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** text_console_writer: FAILED **");
      $finish;
    end
  end

  // receiver back-pressure, drawn fresh every cycle
  always @(posedge clk) begin
    rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  // apply one command to the shadow console and return the status it reports
  function automatic tcw_rsp_t console_step(input tcw_req_t item);
    tcw_rsp_t res;
    int       i;
    logic     at_home;
    res = '0;
    at_home = 1'b0;
    case (cmd_t'(item.command))
      CMD_PUT: begin
        if (item.char_code == CHAR_NEWLINE) begin
          cur_col = 0;
          cur_row++;
        end else if (item.char_code == CHAR_BACKSPACE) begin
          // step back in reading order, wrapping to the end of the previous row
          if (cur_col > 0) begin
            cur_col--;
          end else if (cur_row > 0) begin
            cur_row--;
            cur_col = COLUMNS - 1;
          end else begin
            at_home = 1'b1;
          end
          if (!at_home) begin
            screen[cur_row * COLUMNS + cur_col] = CELL_ZERO;
          end
        end else if (item.char_code != CHAR_NULL) begin
          screen[cur_row * COLUMNS + cur_col] = {text_attr, item.char_code};
          cur_col++;
          if (cur_col >= COLUMNS) begin
            cur_col = 0;
            cur_row++;
          end
        end
        // ran off the bottom: move everything up one row, zero the last one
        if (cur_row >= ROWS) begin
          for (i = 0; i < CELLS - COLUMNS; i++) begin
            screen[i] = screen[i + COLUMNS];
          end
          for (i = CELLS - COLUMNS; i < CELLS; i++) begin
            screen[i] = CELL_ZERO;
          end
          cur_row = ROWS - 1;
          res.scrolled = 1'b1;
        end
      end
      CMD_READ: begin
        if (item.cell_row < ROWS && item.cell_col < COLUMNS) begin
          res.cell_value = screen[item.cell_row * COLUMNS + item.cell_col];
        end
      end
      CMD_CLEAR: begin
        text_attr = ATTR_RESET;
        cur_col = 0;
        cur_row = 0;
        for (i = 0; i < CELLS; i++) begin
          screen[i] = CELL_BLANK;
        end
      end
      default: begin
      end
    endcase
    res.cursor_col = COL_W'(cur_col);
    res.cursor_row = ROW_W'(cur_row);
    return res;
  endfunction

  // compare every accepted response with the oldest prediction
  always @(posedge clk) begin : check_status
    tcw_rsp_t want;
    if (!rst && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
      if (status_due.size() == 0) begin
        $error("response with no request outstanding");
        mismatch_count++;
      end else begin
        want = status_due.pop_front();
        if (rsp.cursor_col !== want.cursor_col) begin
          $error("cursor_col: expected %0d, got %0d", want.cursor_col, rsp.cursor_col);
          mismatch_count++;
        end
        if (rsp.cursor_row !== want.cursor_row) begin
          $error("cursor_row: expected %0d, got %0d", want.cursor_row, rsp.cursor_row);
          mismatch_count++;
        end
        if (rsp.cell_value !== want.cell_value) begin
          $error("cell_value: expected %h, got %h", want.cell_value, rsp.cell_value);
          mismatch_count++;
        end
        if (rsp.scrolled !== want.scrolled) begin
          $error("scrolled: expected %0d, got %0d", want.scrolled, rsp.scrolled);
          mismatch_count++;
        end
      end
    end
  end

  function automatic tcw_req_t pack_command(input cmd_t c, input logic [7:0] ch,
                                            input int row, input int col);
    tcw_req_t item;
    item.command   = c;
    item.char_code = ch;
    item.cell_row  = ROW_W'(row);
    item.cell_col  = COL_W'(col);
    return item;
  endfunction

  // one request transaction; the prediction is taken at the accepting edge
  task automatic send_command(input tcw_req_t item);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req       <= item;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall !== 1'b0) @(posedge clk);
    status_due.push_back(console_step(item));
  endtask

  task automatic put_char(input logic [7:0] ch);
    send_command(pack_command(CMD_PUT, ch, $urandom_range(0, 63), $urandom_range(0, 127)));
  endtask

  task automatic read_cell(input int row, input int col);
    send_command(pack_command(CMD_READ, 8'($urandom_range(0, 255)), row, col));
  endtask

  // hold off new requests until every response is back and the block is idle
  task automatic wait_drained();
    req_valid <= 1'b0;
    @(posedge clk);
    while (status_due.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // attribute register write, only ever issued with the block idle
  task automatic write_attribute(input logic [7:0] value);
    wait_drained();
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    text_attr = value;
    cfg_valid <= 1'b0;
  endtask

  // clear fills every cell, so no cell read afterwards is undefined;
  // also shows that clear puts the attribute back to its reset value
  task automatic test_clear_restores_defaults();
    write_attribute(8'h5A);
    send_command(pack_command(CMD_CLEAR, 8'hFF, 63, 127));
    put_char(8'h41);
    read_cell(0, 0);
    read_cell(ROWS - 1, COLUMNS - 1);
  endtask

  // extreme byte values and attributes
  task automatic test_character_extremes();
    write_attribute(8'h00);
    put_char(8'h01);
    put_char(8'hFF);
    put_char(8'h80);
    write_attribute(8'hFF);
    put_char(8'h7F);
    read_cell(0, 1);
    read_cell(0, 4);
  endtask

  // null byte, unused command, newline, backspace across a row and at home
  task automatic test_control_bytes();
    put_char(CHAR_NULL);
    send_command(pack_command(CMD_NOP, 8'hFF, 63, 127));
    put_char(CHAR_NEWLINE);
    put_char(CHAR_BACKSPACE);
    read_cell(0, COLUMNS - 1);
    put_char(CHAR_BACKSPACE);
    send_command(pack_command(CMD_CLEAR, 8'h00, 0, 0));
    put_char(CHAR_BACKSPACE);
  endtask

  // positions just past and far past the screen read as zero
  task automatic test_read_bounds();
    read_cell(ROWS, 0);
    read_cell(0, COLUMNS);
    read_cell(63, 127);
    read_cell(0, 0);
  endtask

  // mostly text with newlines and backspaces, so the cursor reaches the
  // bottom row and scrolls; reads lean toward the cursor row
  function automatic tcw_req_t random_command();
    tcw_req_t    item;
    int unsigned pick;
    int unsigned where;
    item = pack_command(CMD_PUT, 8'($urandom_range(0, 255)), $urandom_range(0, 63),
                        $urandom_range(0, 127));
    pick = $urandom_range(0, 999);
    if (pick < 3) begin
      item.command = CMD_CLEAR;
    end else if (pick < 520) begin
      item.command = CMD_PUT;
    end else if (pick < 610) begin
      item.char_code = CHAR_NEWLINE;
    end else if (pick < 690) begin
      item.char_code = CHAR_BACKSPACE;
    end else if (pick < 705) begin
      item.char_code = CHAR_NULL;
    end else if (pick < 720) begin
      item.command = CMD_NOP;
    end else begin
      item.command = CMD_READ;
      where = $urandom_range(0, 9);
      if (where < 4) begin
        item.cell_row = ROW_W'(cur_row);
        item.cell_col = COL_W'($urandom_range(0, COLUMNS - 1));
      end else if (where < 9) begin
        item.cell_row = ROW_W'($urandom_range(0, ROWS - 1));
        item.cell_col = COL_W'($urandom_range(0, COLUMNS - 1));
      end
    end
    return item;
  endfunction

  task automatic test_random_traffic(input int count, input int send_pct,
                                     input int recv_pct, input logic [7:0] attr);
    int n;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    write_attribute(attr);
    for (n = 0; n < count; n++) begin
      // now and then stop, let everything drain and change the attribute
      if (n % 160 == 159) begin
        write_attribute(8'($urandom_range(0, 255)));
      end
      send_command(random_command());
    end
  endtask

  initial begin
    send_idle_pct = 36;
    recv_idle_pct = 47;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_clear_restores_defaults();
    test_character_extremes();
    test_control_bytes();
    test_read_bounds();

    test_random_traffic(630, 36, 47, 8'h00);
    test_random_traffic(630, 47, 36, 8'hFF);
    test_random_traffic(640, 0, 0, 8'($urandom_range(0, 255)));

    // final drain, then a short quiet period for any stray response
    wait_drained();
    repeat (20) @(posedge clk);
    if (status_due.size() != 0) begin
      $error("%0d responses never arrived", status_due.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("** text_console_writer: PASSED **");
    end else begin
      $display("** text_console_writer: FAILED **");
    end
    $finish;
  end

endmodule
